// ===== src/swdl_pkg.sv =====
package swdl_pkg;

   // Field widths fixed by the interface.
   localparam int LEN_W       = 5;
   localparam int POS_W       = 32;
   localparam int INDEX_OUT_W = 16;
   localparam int CHAR_W      = 8;
   localparam int CSR_INDEX_W = 4;

   // Request codes.
   localparam logic [1:0] REQ_DICT  = 2'd0;
   localparam logic [1:0] REQ_TEXT  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   // Reset values of the window length registers.
   localparam logic [LEN_W-1:0] LEN_A_RESET = 5'd8;
   localparam logic [LEN_W-1:0] LEN_B_RESET = 5'd9;

   // One hit as it leaves the search engine.
   typedef struct packed {
      logic                   valid;
      logic [POS_W-1:0]       match_start;
      logic [LEN_W-1:0]       match_length;
      logic [INDEX_OUT_W-1:0] dict_index;
      logic                   last_match;
   } hit_type;

endpackage

// ===== src/swdl_dict_mem.sv =====
module swdl_dict_mem #(
   parameter int DEPTH = 65536,
   parameter int WIDTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/swdl_searcher.sv =====
module swdl_searcher #(
   parameter int MAX_WORD    = 16,
   parameter int DICT_DEPTH  = 65536,
   parameter int NUM_LENGTHS = 4
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   input  logic [NUM_LENGTHS-1:0][swdl_pkg::LEN_W-1:0] lens,
   input  logic [MAX_WORD*8-1:0]                       text_window,
   input  logic [$clog2(MAX_WORD+1)-1:0]               window_fill,
   input  logic [swdl_pkg::POS_W-1:0]                  text_pos,
   input  logic [$clog2(DICT_DEPTH+1)-1:0]             word_count,
   output logic                                        rd_en,
   output logic [$clog2(DICT_DEPTH)-1:0]               rd_addr,
   input  logic [MAX_WORD*8-1:0]                       rd_data,
   output logic                                        busy,
   output swdl_pkg::hit_type                           hit
);

   localparam int AW = $clog2(DICT_DEPTH);
   localparam int CW = $clog2(DICT_DEPTH + 1);
   localparam int IW = (NUM_LENGTHS > 1) ? $clog2(NUM_LENGTHS) : 1;
   localparam int KW = MAX_WORD * 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_PROBE,
      ST_COMPARE,
      ST_DONE
   } state_type;

   state_type                       state_ff, state_in;
   logic [IW-1:0]                   idx_ff, idx_in;
   logic [swdl_pkg::LEN_W-1:0]      len_ff, len_in;
   logic [KW-1:0]                   key_ff, key_in;
   logic signed [CW:0]              low_ff, low_in;
   logic signed [CW:0]              high_ff, high_in;
   logic [AW-1:0]                   mid_ff, mid_in;
   swdl_pkg::hit_type               pend_ff, pend_in;
   swdl_pkg::hit_type               hit_ff, hit_in;
   logic [CW:0]                     sum;
   logic [swdl_pkg::LEN_W-1:0]      cur_len;
   logic                            len_ok;
   logic                            last_idx;

   assign cur_len  = lens[idx_ff];
   assign len_ok   = (cur_len != '0) && (32'(cur_len) <= 32'(MAX_WORD))
                     && (32'(cur_len) <= 32'(window_fill));
   assign last_idx = (idx_ff == IW'(NUM_LENGTHS - 1));
   assign sum      = (CW + 1)'(low_ff) + (CW + 1)'(high_ff);

   // Sequencer: one binary search per configured length, a probe and a compare state per probe.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      len_in   = len_ff;
      key_in   = key_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      mid_in   = mid_ff;
      pend_in  = pend_ff;
      hit_in   = hit_ff;
      hit_in.valid = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = sum[AW:1];
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               idx_in        = '0;
               pend_in.valid = 1'b0;
               state_in      = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (len_ok) begin
               // Align the window to the top of the key, zero padded below.
               len_in   = cur_len;
               key_in   = text_window << ((MAX_WORD - int'(cur_len)) * 8);
               low_in   = '0;
               high_in  = $signed((CW + 1)'(word_count)) - 1;
               state_in = ST_PROBE;
            end else if (last_idx) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_PROBE: begin
            if (high_ff >= low_ff) begin
               rd_en    = 1'b1;
               mid_in   = sum[AW:1];
               state_in = ST_COMPARE;
            end else if (last_idx) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_COMPARE: begin
            if (rd_data < key_ff) begin
               low_in   = $signed((CW + 1)'(mid_ff)) + 1;
               state_in = ST_PROBE;
            end else if (rd_data > key_ff) begin
               high_in  = $signed((CW + 1)'(mid_ff)) - 1;
               state_in = ST_PROBE;
            end else begin
               // A hit: the previous one is now known not to be the last.
               if (pend_ff.valid) begin
                  hit_in = pend_ff;
                  hit_in.last_match = 1'b0;
               end
               pend_in.valid        = 1'b1;
               pend_in.match_start  = text_pos - swdl_pkg::POS_W'(len_ff);
               pend_in.match_length = len_ff;
               pend_in.dict_index   = swdl_pkg::INDEX_OUT_W'(mid_ff);
               pend_in.last_match   = 1'b1;
               if (last_idx) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_DONE: begin
            if (pend_ff.valid) begin
               hit_in = pend_ff;
               hit_in.last_match = 1'b1;
            end
            pend_in.valid = 1'b0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_ff.valid <= 1'b0;
         hit_ff.valid  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff.valid <= pend_in.valid;
         hit_ff.valid  <= hit_in.valid;
      end
      idx_ff               <= idx_in;
      len_ff               <= len_in;
      key_ff               <= key_in;
      low_ff               <= low_in;
      high_ff              <= high_in;
      mid_ff               <= mid_in;
      pend_ff.match_start  <= pend_in.match_start;
      pend_ff.match_length <= pend_in.match_length;
      pend_ff.dict_index   <= pend_in.dict_index;
      pend_ff.last_match   <= pend_in.last_match;
      hit_ff.match_start   <= hit_in.match_start;
      hit_ff.match_length  <= hit_in.match_length;
      hit_ff.dict_index    <= hit_in.dict_index;
      hit_ff.last_match    <= hit_in.last_match;
   end

   assign busy = (state_ff != ST_IDLE);
   assign hit  = hit_ff;

endmodule

// ===== src/sliding_window_dictionary_lookup.sv =====
// Dictionary characters and clears are taken without a search. A text
// character is accepted, then busy stays high while the search engine
// walks every length register in turn: one setup state per register
// (all that a disabled or unusable length costs), a probe and a compare
// state per binary-search probe (a read of the dictionary memory, then
// the compare), one more probe state on a miss to see the range empty,
// and one closing state. Each length is searched with at most
// P = floor(log2(word_count)) + 1 probes, each a read over the single read
// port of the dictionary memory. Each hit appears on the rsp_ ports for
// exactly one cycle with rsp_valid high; the receiver cannot stall them,
// and rsp_last_match marks the final hit caused by a character.
module sliding_window_dictionary_lookup #(
   parameter int MAX_WORD    = 16,
   parameter int DICT_DEPTH  = 65536,
   parameter int NUM_LENGTHS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_type,
   input  logic [swdl_pkg::CHAR_W-1:0]         req_char_value,
   input  logic                                req_word_end,
   output logic                                rsp_valid,
   output logic [swdl_pkg::POS_W-1:0]          rsp_match_start,
   output logic [swdl_pkg::LEN_W-1:0]          rsp_match_length,
   output logic [swdl_pkg::INDEX_OUT_W-1:0]    rsp_dict_index,
   output logic                                rsp_last_match,
   input  logic                                csr_write_en,
   input  logic [swdl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [swdl_pkg::LEN_W-1:0]          csr_data
);

   localparam int AW = $clog2(DICT_DEPTH);
   localparam int CW = $clog2(DICT_DEPTH + 1);
   localparam int FW = $clog2(MAX_WORD + 1);
   localparam int LW = $clog2(MAX_WORD + 2);
   localparam int KW = MAX_WORD * 8;
   localparam int IW = (NUM_LENGTHS > 1) ? $clog2(NUM_LENGTHS) : 1;

   logic [NUM_LENGTHS-1:0][swdl_pkg::LEN_W-1:0] lens_ff, lens_in;
   logic [KW-1:0]                  window_ff, window_in;
   logic [FW-1:0]                  fill_ff, fill_in;
   logic [swdl_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [KW-1:0]                  load_ff, load_in;
   logic [LW-1:0]                  load_len_ff, load_len_in;
   logic                           accept;
   logic                           search_busy;
   logic                           wr_en;
   logic [KW-1:0]                  load_word;
   logic                           rd_en;
   logic [AW-1:0]                  rd_addr;
   logic [KW-1:0]                  rd_data;
   swdl_pkg::hit_type              hit;

   assign accept = start && !search_busy;

   // Current partial word with the incoming byte placed at its position.
   always_comb begin
      load_word = load_ff;
      for (int k = 0; k < MAX_WORD; k++) begin
         if (32'(load_len_ff) == k) begin
            load_word[(MAX_WORD - 1 - k) * 8 +: 8] = req_char_value;
         end
      end
   end

   assign wr_en = accept && (req_type == swdl_pkg::REQ_DICT) && req_word_end
                  && (32'(load_len_ff) < 32'(MAX_WORD))
                  && (32'(count_ff) < 32'(DICT_DEPTH));

   // Registers, word loader and text window.
   always_comb begin
      lens_in     = lens_ff;
      window_in   = window_ff;
      fill_in     = fill_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      load_in     = load_ff;
      load_len_in = load_len_ff;
      if (csr_write_en && (32'(csr_index) < 32'(NUM_LENGTHS))) begin
         lens_in[csr_index[IW-1:0]] = csr_data;
      end
      if (accept) begin
         unique case (req_type)
            swdl_pkg::REQ_DICT: begin
               load_in = load_word;
               if (32'(load_len_ff) <= 32'(MAX_WORD)) begin
                  load_len_in = load_len_ff + 1'b1;
               end
               if (req_word_end) begin
                  if (wr_en) begin
                     count_in = count_ff + 1'b1;
                  end
                  load_in     = '0;
                  load_len_in = '0;
               end
            end
            swdl_pkg::REQ_TEXT: begin
               window_in = {window_ff[KW-9:0], req_char_value};
               if (32'(fill_ff) < 32'(MAX_WORD)) begin
                  fill_in = fill_ff + 1'b1;
               end
               pos_in = pos_ff + 1'b1;
            end
            swdl_pkg::REQ_CLEAR: begin
               window_in   = '0;
               fill_in     = '0;
               pos_in      = '0;
               count_in    = '0;
               load_in     = '0;
               load_len_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LENGTHS; i++) begin
            if (i == (1 % NUM_LENGTHS)) begin
               lens_ff[i] <= swdl_pkg::LEN_B_RESET;
            end else if (i == 0) begin
               lens_ff[i] <= swdl_pkg::LEN_A_RESET;
            end else begin
               lens_ff[i] <= '0;
            end
         end
         window_ff   <= '0;
         fill_ff     <= '0;
         pos_ff      <= '0;
         count_ff    <= '0;
         load_ff     <= '0;
         load_len_ff <= '0;
      end else begin
         lens_ff     <= lens_in;
         window_ff   <= window_in;
         fill_ff     <= fill_in;
         pos_ff      <= pos_in;
         count_ff    <= count_in;
         load_ff     <= load_in;
         load_len_ff <= load_len_in;
      end
   end

   // Dictionary storage.
   swdl_dict_mem #(
      .DEPTH (DICT_DEPTH),
      .WIDTH (KW)
   ) u_dict_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (load_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Binary search engine.
   swdl_searcher #(
      .MAX_WORD    (MAX_WORD),
      .DICT_DEPTH  (DICT_DEPTH),
      .NUM_LENGTHS (NUM_LENGTHS)
   ) u_searcher (
      .clock       (clock),
      .reset       (reset),
      .start       (accept && (req_type == swdl_pkg::REQ_TEXT)),
      .lens        (lens_ff),
      .text_window (window_ff),
      .window_fill (fill_ff),
      .text_pos    (pos_ff),
      .word_count  (count_ff),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .busy        (search_busy),
      .hit         (hit)
   );

   assign busy             = search_busy;
   assign rsp_valid        = hit.valid;
   assign rsp_match_start  = hit.match_start;
   assign rsp_match_length = hit.match_length;
   assign rsp_dict_index   = hit.dict_index;
   assign rsp_last_match   = hit.last_match;

endmodule
